>>> rtl/core/frf_pkg.sv
// Shared types and constants of the framed record FIFO.
package frf_pkg;

   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int ID_W        = 16;
   localparam int LEN_W       = 16;
   localparam int FLEN_W      = 6;
   localparam int BYTE_W      = 8;
   localparam int DROP_W      = 32;
   localparam int HDR_BYTES   = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   record_id;
      logic [LEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  read_limit;
   } frf_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     frame_id;
      logic [FLEN_W-1:0]   frame_len;
      logic [BYTE_W-1:0]   data_byte;
      logic                is_data;
      logic                last;
      logic [DROP_W-1:0]   drop_count;
   } frf_rsp_type;

   // Classified command as it travels from the front end to the back end.
   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic              oversize;
      logic [ID_W-1:0]   record_id;
      logic [LEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  read_limit;
   } frf_item_type;

endpackage

>>> rtl/core/frf_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module frf_front #(
   parameter int MAX_PAYLOAD = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  frf_pkg::frf_req_type req_data,
   output logic                 item_valid,
   input  logic                 item_ready,
   output frf_pkg::frf_item_type item
);

   localparam int QPTR_W = (frf_pkg::QUEUE_DEPTH > 1) ? $clog2(frf_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(frf_pkg::QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(frf_pkg::QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(frf_pkg::QUEUE_DEPTH);

   frf_pkg::frf_item_type entry_ff [frf_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   frf_pkg::frf_item_type classified;
   logic push, pop;

   assign req_ready  = (count_ff != QFULL);
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];

   // Unused command codes are swallowed here and never reach the back end.
   assign push = req_valid && req_ready && (req_data.command != frf_pkg::CMD_UNUSED);
   assign pop  = item_valid && item_ready;

   always_comb begin
      classified.op           = req_data.command;
      classified.oversize     = (req_data.payload_len > frf_pkg::LEN_W'(MAX_PAYLOAD));
      classified.record_id    = req_data.record_id;
      classified.payload_len  = req_data.payload_len;
      classified.payload_byte = req_data.payload_byte;
      classified.read_limit   = req_data.read_limit;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QLAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QLAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

>>> rtl/core/frf_back.sv
// Back end: ring buffer memory, frame bookkeeping and the response register.
module frf_back #(
   parameter int BUF_BYTES   = 1024,
   parameter int MAX_PAYLOAD = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  frf_pkg::frf_item_type item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output frf_pkg::frf_rsp_type  rsp_data
);

   localparam int PTR_W  = $clog2(BUF_BYTES);
   localparam int CNT_W  = $clog2(BUF_BYTES + 1);
   localparam int CALC_W = ((CNT_W > frf_pkg::LEN_W) ? CNT_W : frf_pkg::LEN_W) + 1;
   localparam int HC_W   = $clog2(frf_pkg::HDR_BYTES + 1);
   localparam int HDR_W  = frf_pkg::HDR_BYTES * frf_pkg::BYTE_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUF_BYTES - 1);
   localparam logic [CNT_W-1:0] HDR_CNT  = CNT_W'(frf_pkg::HDR_BYTES);
   localparam logic [HC_W-1:0]  HDR_HC   = HC_W'(frf_pkg::HDR_BYTES);
   localparam logic [HC_W-1:0]  HDR_LAST = HC_W'(frf_pkg::HDR_BYTES - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HDRW = 3'd1;
   localparam logic [2:0] S_RDH  = 3'd2;
   localparam logic [2:0] S_RDC  = 3'd3;
   localparam logic [2:0] S_RDD  = 3'd4;

   logic [frf_pkg::BYTE_W-1:0] mem [BUF_BYTES];

   logic [2:0]                  state_ff, state_in;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic [PTR_W-1:0]            ctail_ff, ctail_in;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic [CNT_W-1:0]            comm_ff, comm_in;
   logic [frf_pkg::FLEN_W-1:0]  left_ff, left_in;
   logic                        disc_ff, disc_in;
   logic [frf_pkg::DROP_W-1:0]  drop_ff, drop_in;
   logic                        pend_ff, pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   frf_pkg::frf_rsp_type        rsp_data_ff, rsp_data_in;
   logic [HC_W-1:0]             hcnt_ff, hcnt_in;
   logic [PTR_W-1:0]            raddr_ff, raddr_in;
   logic [HDR_W-1:0]            hdr_ff, hdr_in;
   logic [frf_pkg::LEN_W-1:0]   limit_ff, limit_in;
   logic [frf_pkg::FLEN_W-1:0]  flen_ff, flen_in;
   logic [frf_pkg::FLEN_W-1:0]  didx_ff, didx_in;
   logic [frf_pkg::ID_W-1:0]    cur_id_ff, cur_id_in;
   logic [frf_pkg::LEN_W-1:0]   cur_len_ff, cur_len_in;
   logic [frf_pkg::BYTE_W-1:0]  rd_data_ff;

   logic                        mem_we, mem_re;
   logic [frf_pkg::BYTE_W-1:0]  mem_wdata;
   logic                        out_free;
   logic                        abandon, start_fail;
   logic [CNT_W-1:0]            used_eff;
   logic [CALC_W-1:0]           free_room, need;
   logic [frf_pkg::DROP_W-1:0]  drop_start;
   logic [frf_pkg::ID_W-1:0]    hdr_id;
   logic [frf_pkg::LEN_W-1:0]   hdr_len;
   logic                        too_big;
   logic [CNT_W-1:0]            avail;
   logic [CALC_W-1:0]           len_clamp;
   logic [frf_pkg::FLEN_W-1:0]  flen_sel, fin_flen;
   logic [CNT_W-1:0]            finish_amt;

   function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic frf_pkg::frf_rsp_type make_rsp(
      input logic [frf_pkg::STATUS_W-1:0] status,
      input logic [frf_pkg::ID_W-1:0]     id,
      input logic [frf_pkg::FLEN_W-1:0]   len,
      input logic [frf_pkg::BYTE_W-1:0]   data,
      input logic                         is_data,
      input logic                         last,
      input logic [frf_pkg::DROP_W-1:0]   drops
   );
      frf_pkg::frf_rsp_type r;
      r.status     = status;
      r.frame_id   = id;
      r.frame_len  = len;
      r.data_byte  = data;
      r.is_data    = is_data;
      r.last       = last;
      r.drop_count = drops;
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Frame start checks, done against the buffer after any open frame is released.
   assign abandon    = (used_ff != comm_ff);
   assign used_eff   = abandon ? comm_ff : used_ff;
   assign free_room  = CALC_W'(BUF_BYTES) - CALC_W'(used_eff);
   assign need       = CALC_W'(frf_pkg::HDR_BYTES) + CALC_W'(item.payload_len);
   assign start_fail = item.oversize || (free_room < need);
   assign drop_start = drop_ff + frf_pkg::DROP_W'(abandon) + frf_pkg::DROP_W'(start_fail);

   // Header fields as gathered from memory, low byte first.
   assign hdr_id  = hdr_ff[frf_pkg::ID_W-1:0];
   assign hdr_len = hdr_ff[HDR_W-1:frf_pkg::ID_W];
   assign too_big = (hdr_len > limit_ff);
   assign avail   = comm_ff - HDR_CNT;

   always_comb begin
      len_clamp = CALC_W'(hdr_len);
      if (len_clamp > CALC_W'(avail)) begin
         len_clamp = CALC_W'(avail);
      end
      if (len_clamp > CALC_W'(MAX_PAYLOAD)) begin
         len_clamp = CALC_W'(MAX_PAYLOAD);
      end
   end

   assign flen_sel   = len_clamp[frf_pkg::FLEN_W-1:0];
   assign fin_flen   = (state_ff == S_RDC) ? flen_sel : flen_ff;
   assign finish_amt = HDR_CNT + CNT_W'(fin_flen);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      ctail_in    = ctail_ff;
      used_in     = used_ff;
      comm_in     = comm_ff;
      left_in     = left_ff;
      disc_in     = disc_ff;
      drop_in     = drop_ff;
      pend_in     = pend_ff;
      hcnt_in     = hcnt_ff;
      raddr_in    = raddr_ff;
      hdr_in      = hdr_ff;
      limit_in    = limit_ff;
      flen_in     = flen_ff;
      didx_in     = didx_ff;
      cur_id_in   = cur_id_ff;
      cur_len_in  = cur_len_ff;
      rsp_data_in = rsp_data_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_wdata   = '0;
      item_ready  = 1'b0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            item_ready = out_free;
            if (item_valid && out_free) begin
               unique case (item.op)
                  frf_pkg::CMD_START: begin
                     if (abandon) begin
                        tail_in = ctail_ff;
                        used_in = comm_ff;
                        left_in = '0;
                     end
                     disc_in      = 1'b0;
                     drop_in      = drop_start;
                     rsp_valid_in = 1'b1;
                     if (start_fail) begin
                        disc_in     = 1'b1;
                        rsp_data_in = make_rsp(frf_pkg::ST_DROPPED, '0, '0, '0, 1'b0,
                                               1'b1, drop_start);
                     end else begin
                        cur_id_in   = item.record_id;
                        cur_len_in  = item.payload_len;
                        left_in     = item.payload_len[frf_pkg::FLEN_W-1:0];
                        hcnt_in     = '0;
                        state_in    = S_HDRW;
                        rsp_data_in = make_rsp(frf_pkg::ST_OK, item.record_id,
                                               item.payload_len[frf_pkg::FLEN_W-1:0],
                                               '0, 1'b0, 1'b1, drop_start);
                     end
                  end
                  frf_pkg::CMD_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (disc_ff || (left_ff == '0)) begin
                        rsp_data_in = make_rsp(frf_pkg::ST_IGNORED, '0, '0, '0, 1'b0,
                                               1'b1, drop_ff);
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = item.payload_byte;
                        tail_in   = inc_ptr(tail_ff);
                        used_in   = used_ff + 1'b1;
                        left_in   = left_ff - 1'b1;
                        if (left_ff == frf_pkg::FLEN_W'(1)) begin
                           comm_in  = used_ff + 1'b1;
                           ctail_in = inc_ptr(tail_ff);
                        end
                        rsp_data_in = make_rsp(frf_pkg::ST_OK, '0, '0, '0, 1'b0,
                                               1'b1, drop_ff);
                     end
                  end
                  frf_pkg::CMD_READ: begin
                     if (comm_ff < HDR_CNT) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = make_rsp(frf_pkg::ST_EMPTY, '0, '0, '0, 1'b0,
                                                1'b1, drop_ff);
                     end else begin
                        raddr_in = head_ff;
                        hcnt_in  = '0;
                        limit_in = item.read_limit;
                        state_in = S_RDH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_HDRW: begin
            mem_we = 1'b1;
            unique case (hcnt_ff[1:0])
               2'd0: mem_wdata = cur_id_ff[7:0];
               2'd1: mem_wdata = cur_id_ff[15:8];
               2'd2: mem_wdata = cur_len_ff[7:0];
               2'd3: mem_wdata = cur_len_ff[15:8];
            endcase
            tail_in = inc_ptr(tail_ff);
            used_in = used_ff + 1'b1;
            hcnt_in = hcnt_ff + 1'b1;
            if (hcnt_ff == HDR_LAST) begin
               state_in = S_IDLE;
               if (cur_len_ff == '0) begin
                  comm_in  = used_ff + 1'b1;
                  ctail_in = inc_ptr(tail_ff);
               end
            end
         end

         S_RDH: begin
            if (hcnt_ff != HDR_HC) begin
               mem_re   = 1'b1;
               raddr_in = inc_ptr(raddr_ff);
            end
            if (hcnt_ff != '0) begin
               hdr_in = {rd_data_ff, hdr_ff[HDR_W-1:frf_pkg::BYTE_W]};
            end
            hcnt_in = hcnt_ff + 1'b1;
            if (hcnt_ff == HDR_HC) begin
               state_in = S_RDC;
            end
         end

         S_RDC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (too_big) begin
                  rsp_data_in = make_rsp(frf_pkg::ST_TOO_SMALL, hdr_id,
                                         hdr_len[frf_pkg::FLEN_W-1:0], '0, 1'b0, 1'b1,
                                         drop_ff);
                  state_in = S_IDLE;
               end else begin
                  rsp_data_in = make_rsp(frf_pkg::ST_OK, hdr_id, flen_sel, '0, 1'b0,
                                         (flen_sel == '0), drop_ff);
                  if (flen_sel == '0) begin
                     head_in  = raddr_ff;
                     used_in  = used_ff - finish_amt;
                     comm_in  = comm_ff - finish_amt;
                     state_in = S_IDLE;
                  end else begin
                     flen_in  = flen_sel;
                     didx_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_RDD;
                  end
               end
            end
         end

         S_RDD: begin
            if (!pend_ff) begin
               mem_re   = 1'b1;
               raddr_in = inc_ptr(raddr_ff);
               pend_in  = 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(frf_pkg::ST_OK, hdr_id, flen_ff, rd_data_ff, 1'b1,
                                       (didx_ff == flen_ff - 1'b1), drop_ff);
               if (didx_ff == flen_ff - 1'b1) begin
                  head_in  = raddr_ff;
                  used_in  = used_ff - finish_amt;
                  comm_in  = comm_ff - finish_amt;
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  mem_re   = 1'b1;
                  raddr_in = inc_ptr(raddr_ff);
                  didx_in  = didx_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         ctail_ff     <= '0;
         used_ff      <= '0;
         comm_ff      <= '0;
         left_ff      <= '0;
         disc_ff      <= 1'b0;
         drop_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ctail_ff     <= ctail_in;
         used_ff      <= used_in;
         comm_ff      <= comm_in;
         left_ff      <= left_in;
         disc_ff      <= disc_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hcnt_ff     <= hcnt_in;
      raddr_ff    <= raddr_in;
      hdr_ff      <= hdr_in;
      limit_ff    <= limit_in;
      flen_ff     <= flen_in;
      didx_ff     <= didx_in;
      cur_id_ff   <= cur_id_in;
      cur_len_ff  <= cur_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr_ff];
      end
   end

endmodule

>>> rtl/core/framed_record_fifo_top.sv
// Top level of the framed record FIFO: front end, command queue and back end.
//
// Usage: request beats arrive on req_valid/req_ready/req_data and carry one
// command each: start a frame, append one payload byte, or read one frame.
// Every command except the unused code gives at least one response beat on
// rsp_valid/rsp_ready/rsp_data; a read that passes its checks gives a header beat
// followed by one beat per payload byte, with last set on the final beat of the run.
// A frame becomes visible to reads only once its last payload byte is in.
// Flow: a request passes a two-entry queue; a frame start is then decided and
// its header written byte by byte through the single memory write port, a
// payload byte is written straight from idle, and a read fetches the header
// over the registered read port, checks it, then gives one payload byte per
// cycle while the receiver takes them. The ring memory, with one write port
// and one read port, and the one-command-at-a-time back end set this pace.
// When the receiver stalls, the back end holds its result in the
// output register and the queue keeps taking requests until it is full.
// Reset is synchronous and empties the buffer, the queue and the drop count;
// the memory contents are not cleared, as only committed bytes are ever read.
module framed_record_fifo_top #(
   parameter int BUF_BYTES   = 1024,
   parameter int MAX_PAYLOAD = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  frf_pkg::frf_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output frf_pkg::frf_rsp_type rsp_data
);

   // Classified commands handed from the front end to the back end.
   logic                  q_valid;
   logic                  q_ready;
   frf_pkg::frf_item_type q_item;

   frf_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item)
   );

   // The back end owns the ring memory, the frame pointers and the response register.
   frf_back #(
      .BUF_BYTES  (BUF_BYTES),
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // No response beat is offered straight after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered after reset");

   // The back end only takes a command when its response register can be loaded.
   a_take_with_room: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> (!rsp_valid || rsp_ready))
      else $error("command taken while response register was blocked");

   // Payload beats of a read always report success.
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_data) |-> (rsp_data.status == frf_pkg::ST_OK))
      else $error("data beat with failure status");

   // Any failure ends its run at once.
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != frf_pkg::ST_OK)) |-> rsp_data.last)
      else $error("failure beat without last");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench of the framed record FIFO, with a scoreboard class and a cycle watchdog.
`timescale 1ns / 100ps

module tb_top;

   // The block is built with its default sizes, and the predictor mirrors them.
   localparam int RING_BYTES      = 1024;
   localparam int PAYLOAD_MAX     = 63;
   // The receiver's one long hold-off, long enough to fill the command queue many times over.
   localparam int HOLD_OFF_CYCLES = 300;
   // Settling time after the last expected beat; it is meant to cover the slowest read.
   localparam int SETTLE_CYCLES   = 80;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 4000;

   // The scoreboard keeps its own copy of the ring, its pointers and the drop count.
   // Every accepted request is run through this copy at once, and the response beats
   // that it must cause are queued in order. Each response beat from the block is then
   // compared, field by field, with the oldest beat in that queue.
   class frame_ring_ledger;
      logic [frf_pkg::BYTE_W-1:0] ring [RING_BYTES];
      logic [9:0]                 ring_head;
      logic [9:0]                 ring_tail;
      logic [10:0]                fill_level;
      logic [10:0]                committed_level;
      logic [5:0]                 owed_bytes;
      bit                         discarding;
      logic [frf_pkg::DROP_W-1:0] drops;
      frf_pkg::frf_rsp_type       expected_beats [$];
      int unsigned                errors;

      function new();
         foreach (ring[i]) ring[i] = '0;
         ring_head       = '0;
         ring_tail       = '0;
         fill_level      = '0;
         committed_level = '0;
         owed_bytes      = '0;
         discarding      = 1'b0;
         drops           = '0;
         errors          = 0;
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction

      function void queue_beat(logic [frf_pkg::STATUS_W-1:0] status,
                               logic [frf_pkg::ID_W-1:0] id,
                               logic [frf_pkg::FLEN_W-1:0] len,
                               logic [frf_pkg::BYTE_W-1:0] data,
                               bit is_data, bit last);
         frf_pkg::frf_rsp_type beat;
         beat.status     = status;
         beat.frame_id   = id;
         beat.frame_len  = len;
         beat.data_byte  = data;
         beat.is_data    = is_data;
         beat.last       = last;
         beat.drop_count = drops;
         expected_beats.push_back(beat);
      endfunction

      function void put_byte(logic [frf_pkg::BYTE_W-1:0] value);
         ring[ring_tail] = value;
         ring_tail  = ring_tail + 10'd1;
         fill_level = fill_level + 11'd1;
      endfunction

      function logic [frf_pkg::BYTE_W-1:0] peek_byte(int unsigned offset);
         logic [9:0] idx;
         idx = ring_head + 10'(offset);
         return ring[idx];
      endfunction

      function void note_request(frf_pkg::frf_req_type req);
         logic [frf_pkg::ID_W-1:0]  fid;
         logic [frf_pkg::LEN_W-1:0] flen;
         int unsigned               need;
         case (req.command)
            frf_pkg::CMD_START: begin
               need = frf_pkg::HDR_BYTES + req.payload_len;
               // A frame still open is abandoned: its bytes are released and it counts as a drop.
               if (fill_level != committed_level) begin
                  ring_tail  = ring_head + committed_level[9:0];
                  fill_level = committed_level;
                  owed_bytes = '0;
                  drops      = drops + 32'd1;
               end
               discarding = 1'b0;
               if (req.payload_len > PAYLOAD_MAX || RING_BYTES - fill_level < need) begin
                  drops      = drops + 32'd1;
                  discarding = 1'b1;
                  queue_beat(frf_pkg::ST_DROPPED, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  put_byte(req.record_id[7:0]);
                  put_byte(req.record_id[15:8]);
                  put_byte(req.payload_len[7:0]);
                  put_byte(req.payload_len[15:8]);
                  owed_bytes = req.payload_len[5:0];
                  // An empty frame is complete as soon as its header is in.
                  if (req.payload_len == '0) committed_level = fill_level;
                  queue_beat(frf_pkg::ST_OK, req.record_id, req.payload_len[5:0], '0, 1'b0,
                             1'b1);
               end
            end
            frf_pkg::CMD_BYTE: begin
               if (discarding || owed_bytes == '0) begin
                  queue_beat(frf_pkg::ST_IGNORED, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  put_byte(req.payload_byte);
                  owed_bytes = owed_bytes - 6'd1;
                  if (owed_bytes == '0) committed_level = fill_level;
                  queue_beat(frf_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b1);
               end
            end
            frf_pkg::CMD_READ: begin
               if (committed_level < frf_pkg::HDR_BYTES) begin
                  queue_beat(frf_pkg::ST_EMPTY, '0, '0, '0, 1'b0, 1'b1);
               end else begin
                  fid  = {peek_byte(1), peek_byte(0)};
                  flen = {peek_byte(3), peek_byte(2)};
                  if (flen > req.read_limit) begin
                     // The frame stays where it is; only its header is reported.
                     queue_beat(frf_pkg::ST_TOO_SMALL, fid, flen[5:0], '0, 1'b0, 1'b1);
                  end else begin
                     queue_beat(frf_pkg::ST_OK, fid, flen[5:0], '0, 1'b0, flen == '0);
                     for (int i = 0; i < flen; i++)
                        queue_beat(frf_pkg::ST_OK, fid, flen[5:0],
                                   peek_byte(frf_pkg::HDR_BYTES + i), 1'b1, i == flen - 1);
                     ring_head       = ring_head + 10'(frf_pkg::HDR_BYTES + flen);
                     fill_level      = fill_level - 11'(frf_pkg::HDR_BYTES + flen);
                     committed_level = committed_level - 11'(frf_pkg::HDR_BYTES + flen);
                  end
               end
            end
            default: begin
               // The unused code causes no beat and leaves the state alone.
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(frf_pkg::frf_rsp_type got);
         frf_pkg::frf_rsp_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: response beat with none expected, expected nothing, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("frame_id", 32'(want.frame_id), 32'(got.frame_id));
         compare_field("frame_len", 32'(want.frame_len), 32'(got.frame_len));
         compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
         compare_field("is_data", 32'(want.is_data), 32'(got.is_data));
         compare_field("last", 32'(want.last), 32'(got.last));
         compare_field("drop_count", want.drop_count, got.drop_count);
      endfunction

      function bit all_clear();
         if (expected_beats.size() != 0)
            $display("%0t: %0d response beats never arrived, expected 0 left, actual %0d",
                     $time, expected_beats.size(), expected_beats.size());
         return errors == 0 && expected_beats.size() == 0;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   frf_pkg::frf_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   frf_pkg::frf_rsp_type rsp_data;

   frame_ring_ledger ledger;
   bit               timed_out;
   bit               hold_off_request;
   bit               hold_off_done;
   int unsigned      burst_left;

   framed_record_fifo_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response beats are taken at the rising edge, where every output still holds the
   // value it had before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_response(rsp_data);
   end

   // The receiver changes its readiness at the falling edge. It switches between spells
   // of full readiness, light stalling and heavy stalling, and once, when the sender asks
   // for it, it holds off for a long stretch so that the queue fills and input stalls.
   initial begin : receiver
      int unsigned mode;
      int unsigned mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_ready = 1'b0;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = ($urandom_range(0, 3) != 0);
               default: rsp_ready = ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // The sender holds valid low for the given number of cycles.
   task automatic sender_gap(input int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Bursts of random length with random gaps between them, and now and then a long
   // stretch with no gap at all.
   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 120);
         end else begin
            sender_gap($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // One request beat: driven at the falling edge, held until it is accepted at a rising
   // edge, and handed to the scoreboard at that same edge.
   task automatic send_item(input frf_pkg::frf_req_type req);
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_request(req);
      pace_sender();
   endtask

   // Fields that the command does not use carry random values, which the block must ignore.
   function automatic frf_pkg::frf_req_type noisy_request(
      input logic [frf_pkg::CMD_W-1:0] command);
      frf_pkg::frf_req_type req;
      req.command      = command;
      req.record_id    = 16'($urandom_range(0, 65535));
      req.payload_len  = 16'($urandom_range(0, 65535));
      req.payload_byte = 8'($urandom_range(0, 255));
      req.read_limit   = 16'($urandom_range(0, 65535));
      return req;
   endfunction

   task automatic start_frame(input logic [frf_pkg::ID_W-1:0] id,
                              input logic [frf_pkg::LEN_W-1:0] len);
      frf_pkg::frf_req_type req;
      req             = noisy_request(frf_pkg::CMD_START);
      req.record_id   = id;
      req.payload_len = len;
      send_item(req);
   endtask

   task automatic feed_byte(input logic [frf_pkg::BYTE_W-1:0] value);
      frf_pkg::frf_req_type req;
      req              = noisy_request(frf_pkg::CMD_BYTE);
      req.payload_byte = value;
      send_item(req);
   endtask

   task automatic feed_payload(input int unsigned count);
      repeat (count) feed_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic read_frame(input logic [frf_pkg::LEN_W-1:0] limit);
      frf_pkg::frf_req_type req;
      req            = noisy_request(frf_pkg::CMD_READ);
      req.read_limit = limit;
      send_item(req);
   endtask

   // The sender stops and waits until every expected beat has come, then lets the block
   // settle, since an unused command leaves nothing to wait for.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic directed_cases();
      read_frame(16'hFFFF);                          // read of an empty buffer
      feed_byte(8'h5A);                              // byte with no frame open
      send_item(noisy_request(frf_pkg::CMD_UNUSED)); // unused code, no beat at all
      start_frame(16'hFFFF, 16'd0);                  // empty frame, committed at once
      read_frame(16'd0);                             // header only, last on the header beat
      start_frame(16'h0000, 16'd64);                 // just over the payload limit
      feed_byte(8'hFF);                              // ignored while the frame is discarded
      start_frame(16'h8001, 16'hFFFF);               // largest length, dropped
      start_frame(16'hA5C3, 16'd3);
      feed_byte(8'h00);
      feed_byte(8'hFF);
      start_frame(16'h3C5A, 16'd2);                  // abandons the open frame
      feed_byte(8'h81);
      feed_byte(8'h7E);
      feed_byte(8'h11);                              // frame complete, nothing owed
      read_frame(16'd1);                             // limit one short of the length
      read_frame(16'd2);                             // limit equal to the length
      start_frame(16'h00FF, 16'd1);
      feed_byte(8'hFF);
      read_frame(16'hFFFF);
      read_frame(16'hFFFF);                          // empty again
   endtask

   // Mostly well-formed frames and reads with random content, some abandoned frames,
   // and a share of stray bytes, oversized starts and unused codes.
   task automatic random_mix(input int unsigned item_count);
      int unsigned sent;
      int unsigned roll;
      int unsigned len;
      int unsigned fed;
      sent = 0;
      while (sent < item_count) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PAYLOAD_MAX)
                                              : $urandom_range(0, 8);
            fed = len;
            if (len > 0 && $urandom_range(0, 9) == 0) fed = $urandom_range(0, len - 1);
            start_frame(16'($urandom_range(0, 65535)), 16'(len));
            feed_payload(fed);
            sent += 1 + fed;
         end else if (roll < 80) begin
            case ($urandom_range(0, 4))
               0:       read_frame(16'($urandom_range(0, 65535)));
               1:       read_frame(16'($urandom_range(0, 8)));
               default: read_frame(16'hFFFF);
            endcase
            sent++;
         end else if (roll < 88) begin
            feed_byte(8'($urandom_range(0, 255)));
            sent++;
         end else if (roll < 95) begin
            fed = $urandom_range(0, 2);
            start_frame(16'($urandom_range(0, 65535)),
                        16'($urandom_range(PAYLOAD_MAX + 1, 65535)));
            feed_payload(fed);
            sent += 1 + fed;
         end else begin
            send_item(noisy_request(frf_pkg::CMD_UNUSED));
            sent++;
         end
      end
   endtask

   // Fills the ring with empty frames until at most one more header fits, tops it up with
   // one frame that fits exactly, offers one for which there is no room, and reads two
   // frames back. The tail pointer wraps on the way; the rest is left for the
   // random traffic that follows to drain. The long receiver hold-off starts here, so
   // the queue fills and the block stalls its input while the sender keeps offering.
   task automatic fill_ring();
      int unsigned room;
      start_frame(16'($urandom_range(0, 65535)), 16'd0);
      hold_off_request = 1'b1;
      room = RING_BYTES - ledger.fill_level;
      while (room >= 2 * frf_pkg::HDR_BYTES) begin
         start_frame(16'($urandom_range(0, 65535)), 16'd0);
         room = RING_BYTES - ledger.fill_level;
      end
      if (room >= frf_pkg::HDR_BYTES) begin
         start_frame(16'($urandom_range(0, 65535)), 16'(room - frf_pkg::HDR_BYTES));
         feed_payload(room - frf_pkg::HDR_BYTES);
      end
      start_frame(16'($urandom_range(0, 65535)), 16'd5);
      feed_payload(2);
      read_frame(16'hFFFF);
      read_frame(16'd0);
   endtask

   task automatic run_stimulus();
      directed_cases();
      wait_drained();
      random_mix(70);
      wait_drained();
      fill_ring();
      wait_drained();
      random_mix(30);
      wait_drained();
   endtask

   initial begin
      ledger           = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      timed_out        = 1'b0;
      hold_off_request = 1'b0;
      burst_left       = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The stimulus and the watchdog race; whichever ends first ends the run.
      fork
         run_stimulus();
         begin : watchdog
            int unsigned idle;
            idle = 0;
            while (idle < WATCHDOG_LIMIT) begin
               @(posedge clock);
               if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
               else idle++;
            end
            timed_out = 1'b1;
         end
      join_any

      if (!timed_out && ledger.all_clear()) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
